### rtl/imu_moving_average_min_max_unit_defines.svh
// Assertion helpers for the IMU filter. Define NO_ASSERTIONS to drop them.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef IMU_MOVING_AVERAGE_MIN_MAX_UNIT_DEFINES_SVH
`define IMU_MOVING_AVERAGE_MIN_MAX_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define IMA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define IMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define IMA_ASSERT_IMPLY(label, ante, cons)
`define IMA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/ima_pkg.sv
`default_nettype none

package ima_pkg;

    localparam int WINDOW_LEN = 10;

    localparam int NUM_CH     = 9;
    localparam int GYRO_FIRST = 3;
    localparam int MAG_FIRST  = 6;
    localparam int GYRO_NUM   = 3;
    localparam int MAG_NUM    = 3;

    localparam int CH_W       = 4;
    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SUB_W      = 2;

    // window storage: one row of WINDOW_LEN slots per channel
    localparam int SLOT_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int MEM_DEPTH = NUM_CH * WINDOW_LEN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // accumulator and reciprocal divider
    localparam int SUM_W     = DATA_W + $clog2(WINDOW_LEN);
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int PROD_W    = SUM_W + DIV_SHIFT;
    localparam int QUO_W     = DATA_W + 1;

    localparam logic [DIV_SHIFT-1:0] DIV_RECIP =
        DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [ADDR_W-1:0] WIN_LEN_A = ADDR_W'(WINDOW_LEN);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFS_Z = 2'd2;

    localparam logic signed [DATA_W-1:0] GYRO_OFS_X_RST = -16'sd107;
    localparam logic signed [DATA_W-1:0] GYRO_OFS_Y_RST = 16'sd36;
    localparam logic signed [DATA_W-1:0] GYRO_OFS_Z_RST = 16'sd52;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [DATA_W-1:0] sample;
        logic                     new_sample;
    } ima_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered;
        logic signed [DATA_W-1:0] field_min;
        logic signed [DATA_W-1:0] field_max;
    } ima_result_t;

    typedef struct packed {
        logic clear;
        logic acc_en;
        logic abs_en;
        logic mul_en;
    } ima_sum_ctrl_t;

endpackage

`default_nettype wire

### rtl/ima_ram.sv
`default_nettype none

module ima_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 90
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/ima_sum_unit.sv
`default_nettype none

// Shared accumulator followed by a reciprocal divide by WINDOW_LEN,
// truncating toward zero.
module ima_sum_unit (
    input  wire logic                              clk,
    input  wire ima_pkg::ima_sum_ctrl_t            ctrl,
    input  wire logic signed [ima_pkg::DATA_W-1:0] addend,
    output logic signed [ima_pkg::DATA_W-1:0]      avg
);
    import ima_pkg::*;

    logic signed [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [QUO_W-1:0]        quo;

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + SUM_W'(addend);
        end
        if (ctrl.abs_en)
        begin
            // magnitude of the most negative sum wraps to the right unsigned value
            mag_reg <= acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
            neg_reg <= acc_reg[SUM_W-1];
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(DIV_RECIP);
        end
    end

    assign quo = prod_reg[DIV_SHIFT +: QUO_W];
    assign avg = neg_reg ? DATA_W'(~quo + QUO_W'(1)) : DATA_W'(quo);

endmodule

`default_nettype wire

### rtl/imu_moving_average_min_max_unit.sv
`default_nettype none

// Nine-channel IMU moving-average filter (accel xyz, gyro xyz, mag xyz).
// item channel (valid/ready): one item per transfer. new_sample=1 pushes the
//   sample into that channel's 10-slot window and recomputes the held average;
//   new_sample=0 only reads the held average. Channel codes above 8 return
//   all-zero fields and change nothing.
// result channel (valid/ready): exactly one result per item. Gyro results
//   have the per-axis offset subtracted; mag results carry running min/max.
// wr port: wr_en/wr_index/wr_data write the gyro offsets x, y, z (index
//   0..2); other indexes are ignored. Write only when idle.
// Sequence: a push item steps through S_WRITE, S_READ (one RAM read and
//   one add per window slot on the shared accumulator), S_DRAIN, S_ABS,
//   S_MUL (reciprocal multiply) and S_FINISH, where the result commits; a
//   read-only item goes straight to S_FINISH. A new item is taken only
//   once the previous item has committed its result.
// Reset: windows, held averages and mag min/max read as zero (per-slot valid
//   bits), offsets return to -107, 36, 52. No clearing pass is needed.
// Stall: the result register holds while result_ready is low; the next item
//   may still be taken, and its result waits in the commit step until the
//   register frees up.
module imu_moving_average_min_max_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire ima_pkg::ima_item_t               item,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output ima_pkg::ima_result_t                  result,
    input  wire logic                             wr_en,
    input  wire logic [ima_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [ima_pkg::DATA_W-1:0]       wr_data
);
    import ima_pkg::*;

    `include "imu_moving_average_min_max_unit_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_ABS,
        S_MUL,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    ima_result_t result_reg, result_next;
    logic result_valid_reg, result_valid_next;

    // latched item
    logic [CH_W-1:0]          ch_reg;
    logic signed [DATA_W-1:0] sample_reg;
    logic                     push_reg;
    logic [ADDR_W-1:0]        base_reg;

    // window read sequencing
    logic [SLOT_W-1:0] rd_cnt_reg;
    logic              rd_pend_reg;
    logic              vld_q_reg;

    // architectural state
    logic [MEM_DEPTH-1:0]     ent_valid_reg;
    logic [SLOT_W-1:0]        wr_ptr_reg   [NUM_CH];
    logic signed [DATA_W-1:0] held_avg_reg [NUM_CH];
    logic signed [DATA_W-1:0] mag_min_reg  [MAG_NUM];
    logic signed [DATA_W-1:0] mag_max_reg  [MAG_NUM];
    logic signed [DATA_W-1:0] gyro_ofs_reg [GYRO_NUM];

    logic accept;
    logic out_free;
    logic commit;
    logic ch_ok;
    logic is_gyro;
    logic is_mag;
    logic [SUB_W-1:0] gyro_idx;
    logic [SUB_W-1:0] mag_idx;

    logic                     ram_we;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] addend;
    logic signed [DATA_W-1:0] avg_new;
    logic signed [DATA_W-1:0] avg_cur;
    logic signed [DATA_W-1:0] min_new;
    logic signed [DATA_W-1:0] max_new;
    ima_result_t              res_calc;
    ima_sum_ctrl_t            sum_ctrl;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;
    assign commit       = (state_reg == S_FINISH) && out_free;

    // channel decode of the latched item
    assign ch_ok    = (ch_reg < CH_W'(NUM_CH));
    assign is_gyro  = ch_ok && (ch_reg >= CH_W'(GYRO_FIRST)) && (ch_reg < CH_W'(MAG_FIRST));
    assign is_mag   = ch_ok && (ch_reg >= CH_W'(MAG_FIRST));
    assign gyro_idx = SUB_W'(ch_reg - CH_W'(GYRO_FIRST));
    assign mag_idx  = SUB_W'(ch_reg - CH_W'(MAG_FIRST));

    // window RAM: write the new sample at the channel's ring pointer, then
    // read every slot of the row; order does not matter for the sum
    assign ram_we    = (state_reg == S_WRITE);
    assign ram_re    = (state_reg == S_READ);
    assign ram_waddr = base_reg + ADDR_W'(wr_ptr_reg[ch_reg]);
    assign ram_raddr = base_reg + ADDR_W'(rd_cnt_reg);

    ima_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // never-written slots count as zero
    assign addend = vld_q_reg ? $signed(ram_rdata) : '0;

    assign sum_ctrl.clear  = (state_reg == S_WRITE);
    assign sum_ctrl.acc_en = rd_pend_reg;
    assign sum_ctrl.abs_en = (state_reg == S_ABS);
    assign sum_ctrl.mul_en = (state_reg == S_MUL);

    ima_sum_unit u_sum (
        .clk    (clk),
        .ctrl   (sum_ctrl),
        .addend (addend),
        .avg    (avg_new)
    );

    // result of the latched item
    always_comb
    begin
        avg_cur  = '0;
        min_new  = '0;
        max_new  = '0;
        res_calc = '0;
        if (ch_ok)
        begin
            avg_cur = push_reg ? avg_new : held_avg_reg[ch_reg];
            res_calc.filtered = is_gyro ? avg_cur - gyro_ofs_reg[gyro_idx] : avg_cur;
            if (is_mag)
            begin
                min_new = (push_reg && (avg_cur < mag_min_reg[mag_idx])) ?
                          avg_cur : mag_min_reg[mag_idx];
                max_new = (push_reg && (avg_cur > mag_max_reg[mag_idx])) ?
                          avg_cur : mag_max_reg[mag_idx];
                res_calc.field_min = min_new;
                res_calc.field_max = max_new;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.new_sample && (item.channel < CH_W'(NUM_CH))) ?
                                 S_WRITE : S_FINISH;
                end
            end
            S_WRITE:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                if (rd_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_ABS;
            end
            S_ABS:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    result_next       = res_calc;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // item latch and read counter (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg     <= item.channel;
            sample_reg <= item.sample;
            push_reg   <= item.new_sample;
            base_reg   <= ADDR_W'(item.channel) * WIN_LEN_A;
        end
        if (state_reg == S_WRITE)
        begin
            rd_cnt_reg <= '0;
        end
        else if (state_reg == S_READ)
        begin
            rd_cnt_reg <= rd_cnt_reg + SLOT_W'(1);
        end
        if (ram_re)
        begin
            vld_q_reg <= ent_valid_reg[ram_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= ram_re;
        end
    end

    // window bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                wr_ptr_reg[i] <= '0;
            end
        end
        else if (ram_we)
        begin
            ent_valid_reg[ram_waddr] <= 1'b1;
            wr_ptr_reg[ch_reg] <= (wr_ptr_reg[ch_reg] == LAST_SLOT) ?
                                  '0 : wr_ptr_reg[ch_reg] + SLOT_W'(1);
        end
    end

    // held averages and magnetometer extremes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                held_avg_reg[i] <= '0;
            end
            for (int i = 0; i < MAG_NUM; i++)
            begin
                mag_min_reg[i] <= '0;
                mag_max_reg[i] <= '0;
            end
        end
        else if (commit && push_reg && ch_ok)
        begin
            held_avg_reg[ch_reg] <= avg_new;
            if (is_mag)
            begin
                mag_min_reg[mag_idx] <= min_new;
                mag_max_reg[mag_idx] <= max_new;
            end
        end
    end

    // gyro offsets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_ofs_reg[0] <= GYRO_OFS_X_RST;
            gyro_ofs_reg[1] <= GYRO_OFS_Y_RST;
            gyro_ofs_reg[2] <= GYRO_OFS_Z_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_GYRO_OFS_X: gyro_ofs_reg[0] <= $signed(wr_data);
                REG_GYRO_OFS_Y: gyro_ofs_reg[1] <= $signed(wr_data);
                REG_GYRO_OFS_Z: gyro_ofs_reg[2] <= $signed(wr_data);
                default: ;
            endcase
        end
    end

    // ---- checks ----
    // read data only returns during the window sweep
    `IMA_ASSERT_IMPLY(a_rd_pend_in_sweep, rd_pend_reg,
        (state_reg == S_READ) || (state_reg == S_DRAIN))
    // a valid push item always starts the window write
    `IMA_ASSERT_NEXT(a_push_starts_write,
        accept && item.new_sample && (item.channel < CH_W'(NUM_CH)),
        state_reg == S_WRITE)
    // commit always presents a result
    `IMA_ASSERT_NEXT(a_commit_gives_result, commit, result_valid && (state_reg == S_IDLE))
    // extremes start at zero, so min stays <= 0 and max stays >= 0
    `IMA_ASSERT_IMPLY(a_mag_extreme_sign, 1'b1,
        !mag_max_reg[0][DATA_W-1] && !mag_max_reg[1][DATA_W-1] &&
        !mag_max_reg[2][DATA_W-1] && (mag_min_reg[0] <= 16'sd0) &&
        (mag_min_reg[1] <= 16'sd0) && (mag_min_reg[2] <= 16'sd0))

endmodule

`default_nettype wire
